// File: hdl/sas_pkg.sv
package sas_pkg;

    localparam int MAX_LEN = 4096;
    localparam int IDX_W   = $clog2(MAX_LEN + 1);
    localparam int POS_W   = 13;
    localparam int H_W     = IDX_W + 1;
    localparam int SUM_W   = IDX_W + 2;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_ENTRY = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // smallest key range: byte keys run up to 256
    localparam logic [IDX_W-1:0] BYTE_KEY_MAX = IDX_W'(256);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_RDW  = 20'h00002,
        S_INA  = 20'h00004,
        S_INB  = 20'h00008,
        S_CLR  = 20'h00010,
        S_CNA  = 20'h00020,
        S_CNB  = 20'h00040,
        S_CNC  = 20'h00080,
        S_PRA  = 20'h00100,
        S_PRB  = 20'h00200,
        S_SCA  = 20'h00400,
        S_SCP  = 20'h00800,
        S_SCB  = 20'h01000,
        S_SCC  = 20'h02000,
        S_RNA  = 20'h04000,
        S_RNP  = 20'h08000,
        S_RN1  = 20'h10000,
        S_RN2  = 20'h20000,
        S_CPA  = 20'h40000,
        S_CPB  = 20'h80000
    } t_state;

endpackage

// File: hdl/suffix_array_sort_core.sv
// Suffix array builder.
// Input channel (i_in_valid / o_in_stall) carries two request kinds. A load
// request stores one byte; the byte flagged by i_last_byte closes the buffer
// and starts the sort. A read request returns the start position of the
// suffix at i_rank; rank 0 is the empty end suffix.
// Output channel (o_out_valid / i_out_stall) carries at most one result per
// request: status 0 with the byte count when a sort finishes, status 1 with
// a suffix start, status 2 on overflow or an invalid read.
// A read passes through the suffix order memory read and then a register
// for the result. The final load starts a sort: a setup pass that seeds
// the group ranks, then doubling passes of two stable counting sorts,
// renumbering and copy back, all driven by one read-modify-write step on
// a single key count memory. Passes repeat (at most log2(n)+1 of them)
// until every suffix sits in its own group.
// The output register holds a result while the receiver stalls; a new
// request is taken only when the sequencer is idle and the output register
// is empty or being emptied in the same cycle.
// Reset clears the control state, the byte count and the sorted flag; the
// memories need no clearing.
module suffix_array_sort_core
    import sas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [12:0]       i_rank,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_suffix_start,
    output logic [1:0]        o_status
);

    // memories
    logic [7:0]       m_bytes [MAX_LEN];
    logic [IDX_W-1:0] m_rank  [MAX_LEN + 1];
    logic [IDX_W-1:0] m_nrank [MAX_LEN + 1];
    logic [IDX_W-1:0] m_cnt   [MAX_LEN + 1];
    logic [IDX_W-1:0] m_tmp   [MAX_LEN + 1];
    logic [IDX_W-1:0] m_sa    [MAX_LEN + 1];

    t_state           r_state;
    logic [IDX_W-1:0] r_byte_count;
    logic             r_sorted;
    logic             r_ovf;
    logic [IDX_W-1:0] r_i;
    logic [H_W-1:0]   r_h;
    logic             r_pass;
    logic             r_kz;
    logic [IDX_W-1:0] r_key;
    logic [IDX_W-1:0] r_p;
    logic [IDX_W-1:0] r_sum;
    logic [IDX_W-1:0] r_grp;
    logic [IDX_W-1:0] r_k1;
    logic [IDX_W-1:0] r_prev1;
    logic [IDX_W-1:0] r_prev2;
    logic             r_out_valid;
    logic [POS_W-1:0] r_suffix_start;
    logic [1:0]       r_status;

    logic [7:0]       bs_q;
    logic [IDX_W-1:0] rk_q, nrk_q, cnt_q, tmp_q, sa_q;

    logic             bs_we, rk_we, nrk_we, cnt_we, tmp_we, sa_we;
    logic [IDX_W-2:0] bs_wa, bs_ra;
    logic [7:0]       bs_wd;
    logic [IDX_W-1:0] rk_wa, rk_wd, rk_ra;
    logic [IDX_W-1:0] nrk_wa, nrk_wd, nrk_ra;
    logic [IDX_W-1:0] cnt_wa, cnt_wd, cnt_ra;
    logic [IDX_W-1:0] tmp_wa, tmp_wd, tmp_ra;
    logic [IDX_W-1:0] sa_wa, sa_wd, sa_ra;

    logic             in_accept;
    logic [SUM_W-1:0] i_plus_h, p_plus_h;
    logic             ih_ok, ph_ok;
    logic [IDX_W-1:0] key_now;
    logic [IDX_W-1:0] lim;
    logic             last_i;
    logic             new_grp;
    logic [IDX_W-1:0] grp_next;
    logic [IDX_W-1:0] total;

    // handshake
    assign o_in_stall = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid    = r_out_valid;
    assign o_suffix_start = r_suffix_start;
    assign o_status       = r_status;

    // address helpers
    assign i_plus_h = SUM_W'(r_i) + SUM_W'(r_h);
    assign p_plus_h = SUM_W'(r_p) + SUM_W'(r_h);
    assign ih_ok    = i_plus_h <= SUM_W'(r_byte_count);
    assign ph_ok    = p_plus_h <= SUM_W'(r_byte_count);
    assign key_now  = r_kz ? '0 : rk_q;
    assign lim      = (r_byte_count > BYTE_KEY_MAX) ? r_byte_count : BYTE_KEY_MAX;
    assign last_i   = (r_i == r_byte_count);
    assign total    = r_byte_count + IDX_W'(1);
    assign new_grp  = (r_i == '0) || (r_k1 != r_prev1) || (key_now != r_prev2);
    assign grp_next = r_grp + IDX_W'(new_grp);

    // memory port control
    always_comb begin
        bs_we  = 1'b0;  bs_wa  = r_byte_count[IDX_W-2:0]; bs_wd = i_data_byte;
        bs_ra  = r_i[IDX_W-2:0];
        rk_we  = 1'b0;  rk_wa  = r_i;  rk_wd  = '0;  rk_ra  = r_i;
        nrk_we = 1'b0;  nrk_wa = r_p;  nrk_wd = grp_next - IDX_W'(1);  nrk_ra = r_i;
        cnt_we = 1'b0;  cnt_wa = r_i;  cnt_wd = '0;  cnt_ra = key_now;
        tmp_we = 1'b0;  tmp_wa = cnt_q; tmp_wd = r_p; tmp_ra = r_i;
        sa_we  = 1'b0;  sa_wa  = cnt_q; sa_wd  = r_p; sa_ra  = r_i;
        case (r_state)
            S_IDLE: begin
                sa_ra = i_rank;
                if (in_accept && i_req_type == REQ_LOAD) begin
                    bs_we = (r_sorted || r_byte_count < IDX_W'(MAX_LEN));
                    bs_wa = r_sorted ? '0 : r_byte_count[IDX_W-2:0];
                end
            end
            S_INA: begin
                if (last_i) begin
                    rk_we = 1'b1;
                end
            end
            S_INB: begin
                rk_we = 1'b1;
                rk_wd = IDX_W'(bs_q) + IDX_W'(1);
            end
            S_CLR: begin
                cnt_we = 1'b1;
            end
            S_CNA: begin
                rk_ra = r_pass ? r_i : i_plus_h[IDX_W-1:0];
            end
            S_CNC, S_SCC: begin
                cnt_we = 1'b1;
                cnt_wa = r_key;
                cnt_wd = cnt_q + IDX_W'(1);
                tmp_we = (r_state == S_SCC) && !r_pass;
                sa_we  = (r_state == S_SCC) && r_pass;
            end
            S_PRA: begin
                cnt_ra = r_i;
            end
            S_PRB: begin
                cnt_we = 1'b1;
                cnt_wd = r_sum;
            end
            S_SCA: begin
                rk_ra = i_plus_h[IDX_W-1:0];
            end
            S_SCP: begin
                rk_ra = tmp_q;
            end
            S_RNP: begin
                rk_ra = sa_q;
            end
            S_RN1: begin
                rk_ra = p_plus_h[IDX_W-1:0];
            end
            S_RN2: begin
                nrk_we = 1'b1;
            end
            S_CPB: begin
                rk_we = 1'b1;
                rk_wd = nrk_q;
            end
            default: begin
            end
        endcase
    end

    // memory arrays with registered reads
    always_ff @(posedge i_clk) begin
        if (bs_we) begin
            m_bytes[bs_wa] <= bs_wd;
        end
        bs_q <= m_bytes[bs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            m_rank[rk_wa] <= rk_wd;
        end
        rk_q <= m_rank[rk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nrk_we) begin
            m_nrank[nrk_wa] <= nrk_wd;
        end
        nrk_q <= m_nrank[nrk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_cnt[cnt_wa] <= cnt_wd;
        end
        cnt_q <= m_cnt[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tmp_we) begin
            m_tmp[tmp_wa] <= tmp_wd;
        end
        tmp_q <= m_tmp[tmp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sa_we) begin
            m_sa[sa_wa] <= sa_wd;
        end
        sa_q <= m_sa[sa_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_byte_count <= '0;
            r_sorted     <= 1'b0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_i          <= '0;
            r_h          <= '0;
            r_pass       <= 1'b0;
            r_grp        <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_req_type == REQ_LOAD) begin
                            if (r_sorted) begin
                                r_sorted     <= 1'b0;
                                r_byte_count <= IDX_W'(1);
                                r_ovf        <= 1'b0;
                                r_out_valid  <= 1'b0;
                            end else if (r_byte_count < IDX_W'(MAX_LEN)) begin
                                r_byte_count <= r_byte_count + IDX_W'(1);
                                r_ovf        <= 1'b0;
                                r_out_valid  <= 1'b0;
                            end else begin
                                // drop the byte; report now unless a sort follows
                                r_ovf          <= 1'b1;
                                r_out_valid    <= !i_last_byte;
                                r_suffix_start <= '0;
                                r_status       <= ST_ERROR;
                            end
                            if (i_last_byte) begin
                                r_i     <= '0;
                                r_state <= S_INA;
                            end
                        end else if (!r_sorted || i_rank > r_byte_count) begin
                            r_out_valid    <= 1'b1;
                            r_suffix_start <= '0;
                            r_status       <= ST_ERROR;
                        end else begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_RDW;
                        end
                    end else if (r_out_valid && !i_out_stall) begin
                        // drop a delivered result
                        r_out_valid <= 1'b0;
                    end
                end
                S_RDW: begin
                    r_out_valid    <= 1'b1;
                    r_suffix_start <= sa_q;
                    r_status       <= ST_ENTRY;
                    r_state        <= S_IDLE;
                end
                // seed group ranks with byte value plus one, zero for the end suffix
                S_INA: begin
                    if (last_i) begin
                        r_i     <= '0;
                        r_h     <= H_W'(1);
                        r_pass  <= 1'b0;
                        r_state <= S_CLR;
                    end else begin
                        r_state <= S_INB;
                    end
                end
                S_INB: begin
                    r_i     <= r_i + IDX_W'(1);
                    r_state <= S_INA;
                end
                // clear key counts
                S_CLR: begin
                    if (r_i == lim) begin
                        r_i     <= '0;
                        r_state <= S_CNA;
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                    end
                end
                // count keys
                S_CNA: begin
                    r_kz    <= !r_pass && !ih_ok;
                    r_state <= S_CNB;
                end
                S_CNB: begin
                    r_key   <= key_now;
                    r_state <= S_CNC;
                end
                S_CNC: begin
                    if (last_i) begin
                        r_i     <= '0;
                        r_sum   <= '0;
                        r_state <= S_PRA;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_CNA;
                    end
                end
                // exclusive prefix sum
                S_PRA: begin
                    r_state <= S_PRB;
                end
                S_PRB: begin
                    r_sum <= r_sum + cnt_q;
                    if (r_i == lim) begin
                        r_i     <= '0;
                        r_state <= S_SCA;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_PRA;
                    end
                end
                // stable scatter
                S_SCA: begin
                    if (r_pass) begin
                        r_state <= S_SCP;
                    end else begin
                        r_p     <= r_i;
                        r_kz    <= !ih_ok;
                        r_state <= S_SCB;
                    end
                end
                S_SCP: begin
                    r_p     <= tmp_q;
                    r_kz    <= 1'b0;
                    r_state <= S_SCB;
                end
                S_SCB: begin
                    r_key   <= key_now;
                    r_state <= S_SCC;
                end
                S_SCC: begin
                    if (last_i) begin
                        r_i <= '0;
                        if (r_pass) begin
                            r_grp   <= '0;
                            r_state <= S_RNA;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= S_CLR;
                        end
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_SCA;
                    end
                end
                // renumber groups in sorted order
                S_RNA: begin
                    r_state <= S_RNP;
                end
                S_RNP: begin
                    r_p     <= sa_q;
                    r_state <= S_RN1;
                end
                S_RN1: begin
                    r_k1    <= rk_q;
                    r_kz    <= !ph_ok;
                    r_state <= S_RN2;
                end
                S_RN2: begin
                    r_grp   <= grp_next;
                    r_prev1 <= r_k1;
                    r_prev2 <= key_now;
                    if (last_i) begin
                        r_i     <= '0;
                        r_state <= S_CPA;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_RNA;
                    end
                end
                // copy new ranks back, then finish or double
                S_CPA: begin
                    r_state <= S_CPB;
                end
                S_CPB: begin
                    if (last_i) begin
                        r_i <= '0;
                        if (r_grp == total) begin
                            r_sorted       <= 1'b1;
                            r_out_valid    <= 1'b1;
                            r_suffix_start <= r_ovf ? '0 : r_byte_count;
                            r_status       <= r_ovf ? ST_ERROR : ST_DONE;
                            r_state        <= S_IDLE;
                        end else begin
                            r_h     <= {r_h[H_W-2:0], 1'b0};
                            r_pass  <= 1'b0;
                            r_state <= S_CLR;
                        end
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_CPA;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("request taken while sequencer busy");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= IDX_W'(MAX_LEN))
        else $error("byte count beyond capacity");

    a_entry_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_ENTRY) |-> r_sorted)
        else $error("entry returned without a finished sort");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sorted) |-> (r_state == S_IDLE) && r_out_valid)
        else $error("sort finished without result");

endmodule

// File: dv/suffix_array_sort_core_tb.sv
module suffix_array_sort_core_tb;
    import sas_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [1:0]       status;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_req_type = REQ_LOAD;
    logic [7:0]        i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic [12:0]       i_rank = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [POS_W-1:0]  o_suffix_start;
    logic [1:0]        o_status;

    // model of the block state
    logic [7:0] buf_bytes [MAX_LEN];
    int         sfx_order [MAX_LEN+1];
    int         buf_len = 0;
    logic       is_sorted = 1'b0;

    t_result    pending_results [$];
    int         n_mismatch = 0;
    int         n_checked = 0;
    int         n_sorts = 0;
    int         n_requests = 0;
    bit         idle_on = 1'b1;

    suffix_array_sort_core u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // build the suffix order of the buffer plus the empty suffix by prefix doubling
    function automatic void build_order();
        int grp [MAX_LEN+1];
        int ngrp [MAX_LEN+1];
        int tmp [MAX_LEN+1];
        int cnt [];
        int total, span, h, groups, sum, c, p, k1, k2, pk1, pk2;
        total = buf_len + 1;
        span = total + 260;
        cnt = new[span];
        for (int i = 0; i < buf_len; i++) grp[i] = buf_bytes[i] + 1;
        grp[buf_len] = 0;
        for (int i = 0; i < total; i++) sfx_order[i] = i;
        h = 0;
        groups = 0;
        while (groups < total) begin
            // second key: group of p+h, or lowest when past the end
            for (int k = 0; k < span; k++) cnt[k] = 0;
            for (int i = 0; i < total; i++) begin
                k2 = (h > 0 && i + h < total) ? grp[i+h] + 1 : 0;
                cnt[k2]++;
            end
            sum = 0;
            for (int k = 0; k < span; k++) begin
                c = cnt[k]; cnt[k] = sum; sum += c;
            end
            for (int i = 0; i < total; i++) begin
                k2 = (h > 0 && i + h < total) ? grp[i+h] + 1 : 0;
                tmp[cnt[k2]++] = i;
            end
            // first key: current group, stable
            for (int k = 0; k < span; k++) cnt[k] = 0;
            for (int i = 0; i < total; i++) cnt[grp[i]]++;
            sum = 0;
            for (int k = 0; k < span; k++) begin
                c = cnt[k]; cnt[k] = sum; sum += c;
            end
            for (int i = 0; i < total; i++) begin
                p = tmp[i];
                sfx_order[cnt[grp[p]]++] = p;
            end
            // renumber densely
            groups = 0; pk1 = -1; pk2 = -1;
            for (int i = 0; i < total; i++) begin
                p = sfx_order[i];
                k1 = grp[p];
                k2 = (h > 0 && p + h < total) ? grp[p+h] + 1 : 0;
                if (i == 0 || k1 != pk1 || k2 != pk2) groups++;
                ngrp[p] = groups - 1;
                pk1 = k1; pk2 = k2;
            end
            for (int i = 0; i < total; i++) grp[i] = ngrp[i];
            h = (h == 0) ? 1 : h * 2;
        end
        is_sorted = 1'b1;
        n_sorts++;
    endfunction

    // update the model for one accepted request and queue its result
    function automatic void predict_request(logic rq, logic [7:0] b, logic lst,
                                            logic [12:0] rk);
        t_result r;
        bit ovf;
        ovf = 1'b0;
        if (rq == REQ_LOAD) begin
            if (is_sorted) begin
                is_sorted = 1'b0;
                buf_len = 0;
            end
            if (buf_len >= MAX_LEN) ovf = 1'b1;
            else buf_bytes[buf_len++] = b;
            if (lst) build_order();
            if (ovf) begin
                r.start = '0; r.status = ST_ERROR;
                pending_results.push_back(r);
            end else if (lst) begin
                r.start = POS_W'(buf_len); r.status = ST_DONE;
                pending_results.push_back(r);
            end
        end else begin
            if (!is_sorted || rk > buf_len) begin
                r.start = '0; r.status = ST_ERROR;
            end else begin
                r.start = POS_W'(sfx_order[rk]); r.status = ST_ENTRY;
            end
            pending_results.push_back(r);
        end
    endfunction

    // send one request; called at a rising edge, returns at the accepting edge
    task automatic send_request(logic rq, logic [7:0] b, logic lst, logic [12:0] rk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= rq;
        i_data_byte <= b;
        i_last_byte <= lst;
        i_rank      <= rk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(rq, b, lst, rk);
        n_requests++;
    endtask

    task automatic load_byte(logic [7:0] b, logic lst);
        send_request(REQ_LOAD, b, lst, 13'($urandom));
    endtask

    task automatic read_rank(logic [12:0] rk);
        send_request(REQ_READ, 8'($urandom), 1'($urandom), rk);
    endtask

    task automatic read_all_ranks();
        for (int r = 0; r <= buf_len + 1; r++) read_rank(13'(r));
    endtask

    task automatic test_read_before_sort();
        read_rank(13'd0);
        read_rank(13'h1FFF);
    endtask

    task automatic test_short_buffers();
        load_byte(8'hFF, 1'b1);
        read_all_ranks();
        // repeated byte: every suffix is a prefix of a longer one
        for (int i = 0; i < 5; i++) load_byte(8'h00, i == 4);
        read_all_ranks();
        // reload after a sort starts a new buffer
        load_byte(8'hA5, 1'b0);
        load_byte(8'h5A, 1'b1);
        read_all_ranks();
        read_rank(13'h1FFF);
    endtask

    task automatic test_random_buffers(int n_items);
        int start_cnt, len, alpha, rk;
        start_cnt = n_requests;
        while (n_requests - start_cnt < n_items) begin
            if (n_requests - start_cnt > n_items * 4 / 5) idle_on = 1'b0;
            len = $urandom_range(1, 24);
            alpha = $urandom_range(0, 2);
            for (int i = 0; i < len; i++) begin
                // noise: a read in the middle of a load
                if ($urandom_range(0, 15) == 0) read_rank(13'($urandom));
                case (alpha)
                    0: load_byte(8'($urandom_range(0, 1)) ^ 8'h80, i == len - 1);
                    1: load_byte(8'($urandom_range(0, 3)) << 6, i == len - 1);
                    default: load_byte(8'($urandom), i == len - 1);
                endcase
            end
            repeat ($urandom_range(2, 10)) begin
                case ($urandom_range(0, 7))
                    0: rk = $urandom_range(buf_len + 1, 8191);
                    1: rk = $urandom;
                    default: rk = $urandom_range(0, buf_len);
                endcase
                read_rank(13'(rk));
            end
        end
    endtask

    // receiver stall bursts
    initial begin
        @(posedge i_rst_n);
        while (1) begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: start=%0d status=%0d",
                             o_suffix_start, o_status);
            end else begin
                t_result e;
                e = pending_results.pop_front();
                n_checked++;
                if (e.start !== o_suffix_start || e.status !== o_status) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected start=%0d status=%0d, got %0d %0d",
                                 e.start, e.status, o_suffix_start, o_status);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_read_before_sort();
        test_short_buffers();
        test_random_buffers(400);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) n_mismatch++;
        $display("covered %0d requests, %0d sorts, %0d results checked",
                 n_requests, n_sorts, n_checked);
        $display("short and random buffers, reads before sorting and out of range");
        if (n_mismatch == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches in total", n_mismatch);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // hard limit on run time
    initial begin
        #400000000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
